// File: rtl/core/mpq_pkg.sv
// Package with the constants, opcodes and cell command type of the priority queue.
package mpq_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_PEEK     = 2'd1,
        OP_POP      = 2'd2,
        OP_PEEK_ALT = 2'd3
    } t_opcode;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic signed [VALUE_W-1:0] key;
    } t_cell_cmd;

endpackage

// File: rtl/core/mpq_cell.sv
// One cell of the sorted chain: holds a value, takes a neighbor's value on push or pop.
module mpq_cell (
    input  logic                               i_clk,
    input  mpq_pkg::t_cell_cmd                 i_cmd,
    input  logic                               i_occupied,
    input  logic signed [mpq_pkg::VALUE_W-1:0] i_left_entry,
    input  logic                               i_left_stay,
    input  logic signed [mpq_pkg::VALUE_W-1:0] i_right_entry,
    output logic signed [mpq_pkg::VALUE_W-1:0] o_entry,
    output logic                               o_stay
);
    import mpq_pkg::*;

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;

    // An empty cell counts as larger than any key.
    assign o_stay  = i_occupied && (r_entry <= i_cmd.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.push) begin
            if (!o_stay) begin
                // The key lands in the first cell whose left neighbor stays put.
                n_entry = i_left_stay ? i_cmd.key : i_left_entry;
            end
        end else if (i_cmd.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: rtl/core/min_priority_queue_core.sv
// Top level of the bounded min-priority queue built as a sorted chain of cells.
// The queue keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells, the smallest in cell 0. Every request (push, peek, pop then peek) gives one
// response with the minimum after the operation, an empty flag and an overflow flag;
// a push into a full queue is dropped and flagged. All cells compare the key against
// their own value in parallel and shift by one place in the same clock edge, and the
// response lands in an output register that the next request may replace as soon as
// it is taken. The queue takes one request per cycle while no response is held back.
module min_priority_queue_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_opcode,
    input  logic signed [mpq_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [mpq_pkg::VALUE_W-1:0] o_min_value,
    output logic                               o_is_empty,
    output logic                               o_overflow
);
    import mpq_pkg::*;

    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        n_count;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic signed [VALUE_W-1:0] r_min;
    logic signed [VALUE_W-1:0] n_min;
    logic                      r_empty;
    logic                      n_empty;
    logic                      r_ovf;
    logic                      n_ovf;

    logic                      accept;
    logic                      full;
    logic                      empty;
    t_opcode                   opcode;
    t_cell_cmd                 cmd;

    logic signed [VALUE_W-1:0] entry [CAPACITY];
    logic                      stay  [CAPACITY];

    assign opcode     = t_opcode'(i_opcode);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == COUNT_W'(CAPACITY));
    assign empty      = (r_count == '0);

    assign cmd.push = accept && (opcode == OP_PUSH) && !full;
    assign cmd.pop  = accept && (opcode == OP_POP) && !empty;
    assign cmd.key  = i_value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] left_entry;
        logic                      left_stay;
        logic signed [VALUE_W-1:0] right_entry;

        if (g == 0) begin : g_head
            assign left_entry = cmd.key;
            assign left_stay  = 1'b1;
        end else begin : g_body
            assign left_entry = entry[g-1];
            assign left_stay  = stay[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_entry = entry[g];
        end else begin : g_mid
            assign right_entry = entry[g+1];
        end

        mpq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_occupied    (r_count > COUNT_W'(g)),
            .i_left_entry  (left_entry),
            .i_left_stay   (left_stay),
            .i_right_entry (right_entry),
            .o_entry       (entry[g]),
            .o_stay        (stay[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_min       = r_min;
        n_empty     = r_empty;
        n_ovf       = r_ovf;
        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (accept) begin
            n_out_valid = 1'b1;
            n_ovf       = 1'b0;
            case (opcode)
                OP_PUSH: begin
                    n_empty = 1'b0;
                    if (full) begin
                        n_ovf = 1'b1;
                        n_min = entry[0];
                    end else begin
                        n_count = r_count + COUNT_W'(1);
                        n_min   = (empty || (i_value < entry[0])) ? i_value : entry[0];
                    end
                end
                OP_POP: begin
                    if (!empty) begin
                        n_count = r_count - COUNT_W'(1);
                    end
                    // After the pop the old second entry is the new minimum.
                    n_empty = (r_count <= COUNT_W'(1));
                    n_min   = (r_count <= COUNT_W'(1)) ? '0 : entry[1];
                end
                default: begin
                    n_empty = empty;
                    n_min   = empty ? '0 : entry[0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min   <= n_min;
        r_empty <= n_empty;
        r_ovf   <= n_ovf;
    end

    assign o_out_valid = r_out_valid;
    assign o_min_value = r_min;
    assign o_is_empty  = r_empty;
    assign o_overflow  = r_ovf;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the min-priority queue core: directed and random push/peek/pop traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mpq_pkg::*;

    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
    localparam int LONG_HOLD    = 150;
    localparam int PHASE_ITEMS  = 310;
    localparam int SETTLE_LAT   = 10;
    localparam int REPORT_FIRST = 10;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_traffic_mix;

    typedef struct {
        logic signed [VALUE_W-1:0] min_value;
        logic                      is_empty;
        logic                      overflow;
    } t_queue_status;

    // Predicts the queue status after each request and checks the responses in order.
    class pq_scoreboard;
        logic signed [VALUE_W-1:0] held_values[$];
        t_queue_status             status_q[$];
        int                        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int occupancy();
            return held_values.size();
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_FIRST)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void note_request(t_opcode op, logic signed [VALUE_W-1:0] val);
            t_queue_status st;
            int            pos;
            st.overflow = 1'b0;
            if (op == OP_PUSH) begin
                if (held_values.size() < CAPACITY) begin
                    pos = held_values.size();
                    while (pos > 0 && held_values[pos-1] > val)
                        pos--;
                    held_values.insert(pos, val);
                end else begin
                    st.overflow = 1'b1;
                end
            end else if (op == OP_POP) begin
                if (held_values.size() > 0)
                    void'(held_values.pop_front());
            end
            if (held_values.size() > 0) begin
                st.min_value = held_values[0];
                st.is_empty  = 1'b0;
            end else begin
                st.min_value = '0;
                st.is_empty  = 1'b1;
            end
            status_q.insert(status_q.size(), st);
        endfunction

        function void check_response(logic signed [VALUE_W-1:0] min_value,
                                     logic is_empty, logic overflow);
            t_queue_status st;
            if (status_q.size() == 0) begin
                report($sformatf("response with nothing outstanding: min=%0d empty=%b ovf=%b",
                                 min_value, is_empty, overflow));
                return;
            end
            st = status_q.pop_front();
            if (min_value !== st.min_value || is_empty !== st.is_empty
                    || overflow !== st.overflow)
                report($sformatf("exp min=%0d empty=%b ovf=%b, got min=%0d empty=%b ovf=%b",
                                 st.min_value, st.is_empty, st.overflow,
                                 min_value, is_empty, overflow));
        endfunction

        function void flush_leftovers();
            while (status_q.size() > 0) begin
                void'(status_q.pop_front());
                report("expected response never arrived");
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    t_opcode                   in_opcode = OP_PEEK;
    logic signed [VALUE_W-1:0] in_value = '0;
    logic                      out_ready = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [VALUE_W-1:0] o_min_value;
    logic                      o_is_empty;
    logic                      o_overflow;

    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_requests = 0;
    int           hold_served = 0;
    int           hold_left = 0;
    int           quiet_cycles = 0;
    t_traffic_mix mix = MIX_FILL;
    pq_scoreboard sb = new();

    min_priority_queue_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (in_opcode),
        .i_value     (in_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_min_value (o_min_value),
        .o_is_empty  (o_is_empty),
        .o_overflow  (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Response side: random stalls, plus an occasional long hold-off.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            out_ready   <= 1'b0;
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Handshake monitor and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready)
                sb.note_request(in_opcode, in_value);
            if (o_out_valid && out_ready)
                sb.check_response(o_min_value, o_is_empty, o_overflow);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input t_opcode op, input logic signed [VALUE_W-1:0] val);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_value  <= val;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_responses();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3, 4:    return $signed($urandom_range(16)) - 8;  // many duplicates
            5: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom_range(2000)) - 1000;
        endcase
    endfunction

    function automatic t_opcode pick_opcode();
        int roll;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:  if (roll < 85) return OP_PUSH;
            MIX_DRAIN: if (roll < 85) return OP_POP;
            default:   if (roll < 40) return OP_PUSH; else if (roll < 75) return OP_POP;
        endcase
        return ($urandom_range(1) != 0) ? OP_PEEK : OP_PEEK_ALT;
    endfunction

    task automatic run_phase(input int sender_idle, input int receiver_stall);
        t_opcode op;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            case (mix)
                MIX_FILL:  if (sb.occupancy() >= CAPACITY && $urandom_range(3) == 0)
                               mix = MIX_DRAIN;
                MIX_DRAIN: if (sb.occupancy() == 0 && $urandom_range(3) == 0)
                               mix = MIX_BALANCED;
                default:   if ($urandom_range(49) == 0) mix = MIX_FILL;
            endcase
            if (n == PHASE_ITEMS / 3)
                hold_requests++;
            op = pick_opcode();
            send_request(op, (op == OP_PUSH) ? pick_value() : $signed($urandom));
        end
        drain_responses();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, extremes, duplicates, all opcodes.
        send_request(OP_POP, 32'sh7fff_ffff);
        send_request(OP_PEEK, -32'sd1);
        send_request(OP_PEEK_ALT, 32'sh8000_0000);
        send_request(OP_PUSH, 32'sd0);
        send_request(OP_PUSH, 32'sh7fff_ffff);
        send_request(OP_PUSH, 32'sh8000_0000);
        send_request(OP_PEEK, 32'sd0);
        send_request(OP_PEEK_ALT, -32'sd1);
        send_request(OP_PUSH, -32'sd1);
        send_request(OP_PUSH, 32'sh8000_0000);
        for (int k = 0; k < 6; k++)
            send_request(OP_POP, -32'sd1);
        send_request(OP_PUSH, 32'sd5);
        send_request(OP_PUSH, 32'sd5);
        send_request(OP_PUSH, 32'sh7fff_ffff);
        send_request(OP_POP, 32'sd0);
        send_request(OP_POP, 32'sd0);
        send_request(OP_POP, 32'sd0);
        send_request(OP_PEEK, 32'sd0);
        drain_responses();

        run_phase(0, 0);
        run_phase(48, 0);
        run_phase(0, 48);
        run_phase(24, 24);

        repeat (SETTLE_LAT) @(posedge i_clk);
        sb.flush_leftovers();
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/min_priority_queue_core.sv
verif/testbench.sv
